// ===== rtl/lgge_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the life grid generation engine.
// No dependencies; imported by lgge_gen_row and by the top level.
package lgge_pkg;

  // Operation carried by an input word.
  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_CLR  = 2'd1,
    KIND_GEN  = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_GEN,
    S_OUT
  } state_t;

  // Rule B3/S23: neighbour counts for birth and for survival.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

// ===== rtl/lgge_row_mem.sv =====
`timescale 1ns / 1ps
// Row store of the grid: one synchronous memory with a registered read port,
// plus one valid flag per row so that unwritten rows read as all dead.
module lgge_row_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] row_vld_r;
  logic [WIDTH-1:0] q_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r     <= mem_q[rd_addr];
      q_vld_r <= row_vld_r[rd_addr];
    end
  end

  // A row counts as dead until it has been written once since reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

// ===== rtl/lgge_gen_row.sv =====
`timescale 1ns / 1ps
// Next-generation logic for one row from a three-row window (B3/S23).
// Depends on lgge_pkg for the rule constants.
module lgge_gen_row
  import lgge_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] above,
  input  logic [WIDTH-1:0] centre,
  input  logic [WIDTH-1:0] below,
  output logic [WIDTH-1:0] next_row
);

  logic [WIDTH+1:0] a_x;
  logic [WIDTH+1:0] c_x;
  logic [WIDTH+1:0] b_x;

  // Pad a dead cell on both ends so the edges see no wrap.
  assign a_x = {1'b0, above, 1'b0};
  assign c_x = {1'b0, centre, 1'b0};
  assign b_x = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] cnt;
    cnt = '0;
    for (int c = 0; c < WIDTH; c++) begin
      cnt = {3'b0, a_x[c]} + {3'b0, a_x[c+1]} + {3'b0, a_x[c+2]}
          + {3'b0, c_x[c]} + {3'b0, c_x[c+2]}
          + {3'b0, b_x[c]} + {3'b0, b_x[c+1]} + {3'b0, b_x[c+2]};
      next_row[c] = (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && c_x[c+1]);
    end
  end

endmodule

// ===== rtl/life_grid_generation_engine.sv =====
`timescale 1ns / 1ps
// Life grid generation engine: Conway's Game of Life (B3/S23) on a square grid
// of GRID_SIZE x GRID_SIZE cells, held row by row in one synchronous memory.
// Depends on lgge_pkg, lgge_row_mem and lgge_gen_row.
//
// Usage. The input channel (in_valid, in_stall, in_kind, in_row, in_col)
// carries one word per operation: set a cell alive, clear a cell, advance one
// generation, or read a cell. Every word yields exactly one result word on the
// output channel (out_valid, out_stall, out_alive): the addressed cell's value
// after the operation, or 0 when the address lies off the grid.
// Set, clear and read are a read-modify-write of one row: the row is read on
// acceptance and, for set and clear, written back modified in S_RMW. An advance
// sweeps the rows through a three-row window, one memory read and one memory
// write per cycle, as the single memory port pair allows. Either way the result
// is loaded into the output register from S_OUT, before the return to idle.
// One word is worked on at a time; in_stall is high while it is in flight.
// The output register holds a finished result while the receiver stalls, and
// the next word is accepted meanwhile; its result waits until that register
// is free. Reset clears the per-row valid flags, so the whole grid reads as
// dead at once, and empties the output register. No clearing pass is needed.
module life_grid_generation_engine
  import lgge_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_row,
  input  logic [5:0] in_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_alive
);

  localparam int AW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  // The step counter runs to GRID_SIZE and is also compared one beyond it.
  localparam int CW = $clog2(GRID_SIZE + 2);
  localparam logic [6:0]    GRID_LIM  = 7'(GRID_SIZE);
  localparam logic [CW-1:0] STEP_LAST = CW'(GRID_SIZE);

  state_t state_r, state_nxt;

  logic [CW-1:0]        step_r;
  logic [CW-1:0]        step_plus;
  logic [CW-1:0]        step_minus;
  kind_t                kind_r;
  logic [5:0]           row_r;
  logic [5:0]           col_r;
  logic                 ok_r;
  logic [GRID_SIZE-1:0] prev_r;
  logic [GRID_SIZE-1:0] cur_r;
  logic                 res_r;
  logic                 out_valid_r;
  logic                 out_alive_r;

  logic                 in_acc;
  logic                 in_ok;
  kind_t                in_kind_e;
  logic [GRID_SIZE-1:0] bit_mask;
  logic [GRID_SIZE-1:0] rd_row;
  logic [GRID_SIZE-1:0] below_row;
  logic [GRID_SIZE-1:0] new_row;
  logic [GRID_SIZE-1:0] mod_row;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [GRID_SIZE-1:0] wr_data;
  logic                 load_out;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_kind_e = kind_t'(in_kind);
  assign in_ok     = ({1'b0, in_row} < GRID_LIM) && ({1'b0, in_col} < GRID_LIM);

  assign step_plus  = step_r + 1'b1;
  assign step_minus = step_r - 1'b1;

  // One-hot mask of the addressed column; empty when the column is off the grid.
  assign bit_mask = {{(GRID_SIZE-1){1'b0}}, 1'b1} << col_r;

  // Past the last row the window is fed with a dead row.
  assign below_row = (step_r < STEP_LAST) ? rd_row : '0;

  always_comb begin
    case (kind_r)
      KIND_SET: mod_row = rd_row | bit_mask;
      KIND_CLR: mod_row = rd_row & ~bit_mask;
      default:  mod_row = rd_row;
    endcase
  end

  lgge_row_mem #(
    .DEPTH(GRID_SIZE),
    .WIDTH(GRID_SIZE),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_row),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // The window holds old rows r-2 and r-1 while old row r arrives, so the new
  // row r-1 is written back without disturbing anything still to be read.
  lgge_gen_row #(
    .WIDTH(GRID_SIZE)
  ) u_gen (
    .above   (prev_r),
    .centre  (cur_r),
    .below   (below_row),
    .next_row(new_row)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_kind_e == KIND_GEN) ? S_GEN : S_RMW;
        end
      end
      S_RMW: state_nxt = S_OUT;
      S_GEN: begin
        if (step_r == STEP_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory control and output load.
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = row_r[AW-1:0];
    wr_data  = mod_row;
    load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        rd_en = in_acc;
        if (in_kind_e != KIND_GEN && in_ok) begin
          rd_addr = in_row[AW-1:0];
        end
      end
      S_RMW: begin
        wr_en = ok_r && (kind_r == KIND_SET || kind_r == KIND_CLR);
      end
      S_GEN: begin
        rd_en   = (step_plus < STEP_LAST);
        rd_addr = step_plus[AW-1:0];
        wr_en   = (step_r != '0);
        wr_addr = step_minus[AW-1:0];
        wr_data = new_row;
      end
      S_OUT: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item registers, window and result capture.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_r <= in_kind_e;
          row_r  <= in_row;
          col_r  <= in_col;
          ok_r   <= in_ok;
          step_r <= '0;
          prev_r <= '0;
          cur_r  <= '0;
          res_r  <= 1'b0;
        end
      end
      S_RMW: begin
        res_r <= ok_r && (|(mod_row & bit_mask));
      end
      S_GEN: begin
        step_r <= step_plus;
        prev_r <= cur_r;
        cur_r  <= below_row;
        if (step_r != '0 && ok_r && step_minus[AW-1:0] == row_r[AW-1:0]) begin
          res_r <= |(new_row & bit_mask);
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_alive_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_alive = out_alive_r;

endmodule

// ===== rtl/lgge_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the life grid generation engine, attached by bind.
// Depends only on the top level's ports.
module lgge_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_kind,
  input logic [5:0] in_row,
  input logic [5:0] in_col,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_alive
);

  // A result word held by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alive))
    else $error("result word changed while stalled");

  // An input word held back by the engine stays put.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable({in_kind, in_row, in_col}))
    else $error("input word changed while stalled");

  // One word at a time: after acceptance the input side is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again without a busy cycle");

  // A new result appears only as the engine returns to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while an item is still in flight");

  // Reset leaves the block idle with nothing to deliver.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind life_grid_generation_engine lgge_checker u_lgge_checker (.*);
